// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 5;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

	// one stored entry
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic signed [PRIO_W-1:0]  prio;
	} entry_t;

	// broadcast control for every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t item;
	} cell_ctl_t;

endpackage

// ===== design/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if
// Request and response channels of the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  cmd;
	logic signed [spq_pkg::VALUE_W-1:0]    item_value;
	logic signed [spq_pkg::PRIO_W-1:0]     item_priority;

	modport source (output valid, output cmd, output item_value, output item_priority,
		input ready);
	modport sink (input valid, input cmd, input item_value, input item_priority,
		output ready);
endinterface

interface spq_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [spq_pkg::VALUE_W-1:0]    out_value;
	logic [spq_pkg::STAT_W-1:0]            status;
	logic [spq_pkg::OCC_W-1:0]             occupancy;

	modport source (output valid, output out_value, output status, output occupancy,
		input ready);
	modport sink (input valid, input out_value, input status, input occupancy,
		output ready);
endinterface

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, decides locally whether it
// shifts toward the back on insert, and pulls from its back neighbor on remove.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic               occ,
	input  logic               front_shift,
	input  spq_pkg::entry_t    front_entry,
	input  spq_pkg::entry_t    back_entry,
	output spq_pkg::entry_t    entry,
	output logic               shift
);

	spq_pkg::entry_t entry_q;

	// new item goes before this entry when this slot is empty or not smaller
	assign shift = !occ || (entry_q.prio >= ctl.item.prio);
	assign entry = entry_q;

	// slot update
	always_ff @(posedge clk) begin
		if (ctl.ins && shift) begin
			entry_q <= front_shift ? front_entry : ctl.item;
		end else if (ctl.rem) begin
			entry_q <= back_entry;
		end
	end

endmodule

// ===== design/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue kept sorted by ascending signed priority.
// ----------------------------------------------------------------------------
// A row of CAPACITY cells holds the entries in order, front first. Every cell
// compares the incoming priority with its own entry in the same cycle, so an
// insert or a remove updates every cell at once. One transaction is accepted
// per cycle unless a response stalls, with its result registered next cycle.
// Requests keep flowing while a response waits, as long as the response is
// taken in the same cycle. An insert goes ahead of all stored entries with
// equal or greater priority (newest first among equals); an insert into a full
// queue is dropped with status full, a remove from an empty queue returns
// status empty. out_value is zero except on a successful remove; occupancy is
// the entry count after the transaction, kept to its low five bits.
module sorted_priority_queue_top #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	spq_req_if.sink        req,
	spq_rsp_if.source      rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]              count_q;
	logic                       rsp_valid_q;
	logic signed [spq_pkg::VALUE_W-1:0] rsp_value_q;
	logic [spq_pkg::STAT_W-1:0] rsp_status_q;
	logic [spq_pkg::OCC_W-1:0]  rsp_occ_q;

	logic                       accept;
	logic                       full;
	logic                       empty;
	logic [CW-1:0]              count_next;
	spq_pkg::cell_ctl_t         ctl;

	spq_pkg::entry_t            entries [CAPACITY];
	logic [CAPACITY-1:0]        shifts;

	// handshake and command decode
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);

	assign ctl.ins        = accept && (req.cmd == spq_pkg::CMD_INSERT) && !full;
	assign ctl.rem        = accept && (req.cmd == spq_pkg::CMD_REMOVE) && !empty;
	assign ctl.item.value = req.item_value;
	assign ctl.item.prio  = req.item_priority;

	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + CW'(1);
		end else if (ctl.rem) begin
			count_next = count_q - CW'(1);
		end
	end

	// chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic            occ;
		logic            front_shift;
		spq_pkg::entry_t front_entry;
		spq_pkg::entry_t back_entry;

		assign occ = (CW'(i) < count_q);

		if (i == 0) begin : g_front
			assign front_shift = 1'b0;
			assign front_entry = ctl.item;
		end else begin : g_mid
			assign front_shift = shifts[i-1];
			assign front_entry = entries[i-1];
		end

		if (i == CAPACITY - 1) begin : g_back
			assign back_entry = entries[i];
		end else begin : g_next
			assign back_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ),
			.front_shift (front_shift),
			.front_entry (front_entry),
			.back_entry  (back_entry),
			.entry       (entries[i]),
			.shift       (shifts[i])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// response register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_occ_q   <= spq_pkg::OCC_W'(count_next);
			rsp_value_q <= '0;
			if (req.cmd == spq_pkg::CMD_INSERT) begin
				rsp_status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
			end else if (empty) begin
				rsp_status_q <= spq_pkg::ST_EMPTY;
			end else begin
				rsp_status_q <= spq_pkg::ST_REMOVED;
				rsp_value_q  <= entries[0].value;
			end
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_value = rsp_value_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.occupancy = rsp_occ_q;

endmodule

// ===== design/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_assertions
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_assertions (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [spq_pkg::VALUE_W-1:0] out_value,
	input logic [spq_pkg::STAT_W-1:0]         status,
	input logic [spq_pkg::OCC_W-1:0]          occupancy
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_value) && $stable(status)
			&& $stable(occupancy))
		else $error("response changed while stalled");

	// only a successful remove carries a value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != spq_pkg::ST_REMOVED) |-> out_value == '0)
		else $error("nonzero value on non-remove response");

	// empty report means nothing is held
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == spq_pkg::ST_EMPTY) |-> occupancy == '0)
		else $error("empty status with nonzero occupancy");

	// a remove right after an accepted insert drops occupancy by one
	a_ins_then_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && (status == spq_pkg::ST_INSERTED)
			##1 rsp_valid && (status == spq_pkg::ST_REMOVED)
			|-> $past(occupancy) == occupancy + 5'd1 || $past(occupancy) == 5'd0)
		else $error("occupancy did not drop by one after remove");

endmodule

bind sorted_priority_queue_top spq_assertions u_spq_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.out_value (rsp.out_value),
	.status    (rsp.status),
	.occupancy (rsp.occupancy)
);

// ===== tb/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the sorted priority queue. It keeps its own sorted
// copy of the entries and compares each response with the oldest outcome due.
// ----------------------------------------------------------------------------
module spq_checker #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	spq_req_if   req,
	spq_rsp_if   rsp,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [spq_pkg::VALUE_W-1:0] value;
		logic [spq_pkg::STAT_W-1:0]         status;
		logic [spq_pkg::OCC_W-1:0]          occupancy;
	} outcome_t;

	// sorted shadow copy, front (smallest priority) at index 0
	spq_pkg::entry_t shadow [CAPACITY];
	int              shadow_count;
	outcome_t        outcomes_due [$];
	outcome_t        want;

	initial begin
		errors  = 0;
		pending = 0;
		shadow_count = 0;
	end

	// apply one transaction to the shadow copy and return its outcome
	function automatic outcome_t predict_queue_op(logic op,
			logic signed [spq_pkg::VALUE_W-1:0] v, logic signed [spq_pkg::PRIO_W-1:0] p);
		outcome_t o;
		int slot;
		o = '0;
		if (op == spq_pkg::CMD_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				o.status = spq_pkg::ST_FULL;
			end else begin
				// first entry with priority >= the new one; ties put newest first
				slot = shadow_count;
				for (int i = 0; i < shadow_count; i++) begin
					if (slot == shadow_count && $signed(shadow[i].prio) >= $signed(p))
						slot = i;
				end
				for (int i = shadow_count; i > slot; i--)
					shadow[i] = shadow[i-1];
				shadow[slot].value = v;
				shadow[slot].prio  = p;
				shadow_count++;
				o.status = spq_pkg::ST_INSERTED;
			end
		end else begin
			if (shadow_count == 0) begin
				o.status = spq_pkg::ST_EMPTY;
			end else begin
				o.value = shadow[0].value;
				for (int i = 1; i < shadow_count; i++)
					shadow[i-1] = shadow[i];
				shadow_count--;
				o.status = spq_pkg::ST_REMOVED;
			end
		end
		o.occupancy = shadow_count[spq_pkg::OCC_W-1:0];
		return o;
	endfunction

	// compare responses first, then queue the outcome of a new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			outcomes_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (outcomes_due.size() == 0) begin
					$display("%0t: unexpected response value %0d status %0d occupancy %0d",
						$time, rsp.out_value, rsp.status, rsp.occupancy);
					errors++;
				end else begin
					want = outcomes_due.pop_front();
					if (rsp.out_value !== want.value) begin
						$display("%0t: out_value expected %0d actual %0d",
							$time, want.value, rsp.out_value);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						errors++;
					end
					if (rsp.occupancy !== want.occupancy) begin
						$display("%0t: occupancy expected %0d actual %0d",
							$time, want.occupancy, rsp.occupancy);
						errors++;
					end
				end
			end
			if (req.valid && req.ready)
				outcomes_due.push_back(predict_queue_op(req.cmd, req.item_value,
					req.item_priority));
		end
		pending = outcomes_due.size();
	end

endmodule

// ===== tb/sorted_priority_queue_top_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Drives inserts and removes into the sorted priority queue: a directed pass
// over fill, overflow, ties, extremes and empty removes, then random traffic
// whose insert/remove mix shifts so the queue swings between empty and full.
// Sender bursts and receiver stalls vary; spq_checker does the comparison.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY     = 16;
	localparam int RANDOM_ITEMS = 600;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   burst_left;
	logic [15:0] stall_cycle = '0;

	spq_req_if req ();
	spq_rsp_if rsp ();

	sorted_priority_queue_top #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	spq_checker #(.CAPACITY(CAPACITY)) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// receiver stall pattern: always ready, mostly ready, mostly stalled, periodic
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 16'd1;
		case (stall_cycle[8:7])
			2'd0: rsp.ready <= 1'b1;
			2'd1: rsp.ready <= ($urandom_range(0, 3) != 0);
			2'd2: rsp.ready <= ($urandom_range(0, 3) == 0);
			default: rsp.ready <= (stall_cycle[2:0] < 3'd5);
		endcase
	end

	// one transaction; holds valid across a burst, idles between bursts
	task automatic send_item(logic op, logic [spq_pkg::VALUE_W-1:0] v,
			logic [spq_pkg::PRIO_W-1:0] p);
		req.valid         <= 1'b1;
		req.cmd           <= op;
		req.item_value    <= v;
		req.item_priority <= p;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
		end
	endtask

	// mostly a narrow band to force ties, with extremes and full-range values
	function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(0, 8)) - 16'd4;
		endcase
	endfunction

	function automatic logic [spq_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int insert_pct;
		logic op;
		arst_n            = 1'b0;
		req.valid         = 1'b0;
		req.cmd           = spq_pkg::CMD_INSERT;
		req.item_value    = '0;
		req.item_priority = '0;
		rsp.ready         = 1'b0;
		burst_left        = 5;
		insert_pct        = 50;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: remove from empty, fill with extremes and ties, overflow, drain a few
		send_item(spq_pkg::CMD_REMOVE, 32'h1234_5678, 16'h8000);
		send_item(spq_pkg::CMD_INSERT, 32'h7fff_ffff, 16'h0000);
		send_item(spq_pkg::CMD_INSERT, 32'h8000_0000, 16'h0000);
		send_item(spq_pkg::CMD_INSERT, 32'h0000_0001, 16'h7fff);
		send_item(spq_pkg::CMD_INSERT, 32'hffff_ffff, 16'h8000);
		for (int k = 0; k < 12; k++)
			send_item(spq_pkg::CMD_INSERT, 32'd100 + k, 16'(k % 3) - 16'd1);
		send_item(spq_pkg::CMD_INSERT, 32'hdead_beef, 16'h8000);
		send_item(spq_pkg::CMD_INSERT, 32'hcafe_f00d, 16'h7fff);
		for (int k = 0; k < 4; k++)
			send_item(spq_pkg::CMD_REMOVE, 32'h0, 16'h0);

		// random: the insert share changes every few dozen transactions
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 85;
					1: insert_pct = 50;
					default: insert_pct = 20;
				endcase
			end
			op = ($urandom_range(1, 100) <= insert_pct) ?
				spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE;
			send_item(op, pick_value(), pick_priority());
		end
		req.valid <= 1'b0;

		// give the checker time to log the last request before watching it drain
		repeat (2)
			@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
